/* src/mips32_instruction_execute_defines.svh */
// assertion macros for the mips32 execute block
`ifndef MIPS32_INSTRUCTION_EXECUTE_DEFINES_SVH
`define MIPS32_INSTRUCTION_EXECUTE_DEFINES_SVH
// implication checked on every clock outside reset
`define CHK_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication checked outside reset
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

/* src/m32ie_pkg.sv */
// shared types and constants for the mips32 execute block
`timescale 1ns / 1ps
`default_nettype none
package m32ie_pkg;
  localparam logic [31:0] START_ADDRESS_RESET = 32'h0040_0000;
  localparam logic [1:0] REQ_NONE = 2'd0;
  localparam logic [1:0] REQ_READ = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_UNIMP = 2'd1;
  localparam logic [1:0] ST_MISALIGN = 2'd2;
  localparam logic [1:0] ST_DIVZERO = 2'd3;
  localparam logic OP_EXEC = 1'b0;
  localparam logic OP_LOAD = 1'b1;
  // shared unit operations
  localparam logic [3:0] U_ADD = 4'd0;
  localparam logic [3:0] U_SUB = 4'd1;
  localparam logic [3:0] U_AND = 4'd2;
  localparam logic [3:0] U_OR = 4'd3;
  localparam logic [3:0] U_XOR = 4'd4;
  localparam logic [3:0] U_NOR = 4'd5;
  localparam logic [3:0] U_SLT = 4'd6;
  localparam logic [3:0] U_SLTU = 4'd7;
  localparam logic [3:0] U_SLL = 4'd8;
  localparam logic [3:0] U_SRL = 4'd9;
  localparam logic [3:0] U_SRA = 4'd10;
  localparam logic [3:0] U_LUI = 4'd11;

  typedef struct packed {
    logic        operation;
    logic [31:0] instruction_word;
    logic [31:0] load_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] fetch_address;
    logic [1:0]  memory_request;
    logic [31:0] memory_address;
    logic [31:0] store_data;
    logic [3:0]  byte_enables;
    logic        halted;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;
endpackage
`default_nettype wire

/* src/m32ie_ram.sv */
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module m32ie_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* src/m32ie_alu.sv */
// shared combinational alu and shifter
`timescale 1ns / 1ps
`default_nettype none
module m32ie_alu (
  input  wire m32ie_pkg::alu_req_t req,
  output logic [31:0]              y
);
  import m32ie_pkg::*;
  logic [4:0] sa;
  always_comb begin
    sa = req.a[4:0];
    unique case (req.op)
      U_ADD:  y = req.a + req.b;
      U_SUB:  y = req.a - req.b;
      U_AND:  y = req.a & req.b;
      U_OR:   y = req.a | req.b;
      U_XOR:  y = req.a ^ req.b;
      U_NOR:  y = ~(req.a | req.b);
      U_SLT:  y = {31'd0, $signed(req.a) < $signed(req.b)};
      U_SLTU: y = {31'd0, req.a < req.b};
      U_SLL:  y = req.b << sa;
      U_SRL:  y = req.b >> sa;
      U_SRA:  y = 32'($signed(req.b) >>> sa);
      U_LUI:  y = {req.b[15:0], 16'd0};
      default: y = 32'd0;
    endcase
  end
endmodule
`default_nettype wire

/* src/mips32_instruction_execute.sv */
// top level of the mips32 execute block
`timescale 1ns / 1ps
`default_nettype none
// Multicycle MIPS-I integer core: one transaction in, one transaction out.
// ALU-class and immediate instructions and syscall pass through read rs,
// read rt, execute, writeback on the shared alu and the result register;
// branches, jumps, HI/LO moves, loads, stores, divide by zero and unknown
// instructions skip the writeback step. MULT/MULTU run a 32-step shift-add
// loop and DIV/DIVU a 32-step restoring divide loop, each on its own 33-bit
// adder. A load-data transaction writes the register file before the result
// register when a load is pending; an execute transaction while a load is
// pending or after halt goes straight to the result register. The
// register file is a 32x32 ram with registered read, one read port, so rs
// and rt are fetched in turn. After reset a clearing pass zeroes the
// register file before any input is taken. The result waits in an output
// register; ready drops while a transaction is in flight and comes back the
// cycle after the result is taken. Reset loads the default start address
// into the pc and returns start_address to that default; a later write is
// only held.
module mips32_instruction_execute #(
  parameter logic [31:0] StartReset = m32ie_pkg::START_ADDRESS_RESET
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [31:0]          cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire m32ie_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output m32ie_pkg::out_item_t      out_data
);
  import m32ie_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RDA  = 4'd2;
  localparam logic [3:0] S_RDB  = 4'd3;
  localparam logic [3:0] S_EXE  = 4'd4;
  localparam logic [3:0] S_MUL  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_FIX  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;
  localparam logic [3:0] S_LD   = 4'd9;

  logic [3:0]  state;
  logic [31:0] start_address;
  logic [31:0] pc, hi, lo;
  logic        halt_flag;
  logic        pend;
  logic [2:0]  pend_kind;
  logic [4:0]  pend_tgt;
  logic [1:0]  pend_off;
  logic [31:0] pend_addr;
  logic [31:0] iw, ldw, ra, rb;
  logic [5:0]  cnt;
  logic [4:0]  clr_idx;
  // multiply/divide working registers
  logic [31:0] acc, mq, dv;
  logic        neg_q, neg_r, is_signed;

  // register file ports
  logic        rf_we;
  logic [4:0]  rf_waddr, rf_raddr;
  logic [31:0] rf_wdata, rf_rdata;

  m32ie_ram #(.Width(32), .Depth(32)) u_rf (
    .clk, .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rf_raddr), .rdata(rf_rdata)
  );

  // decode fields
  logic [5:0]  opc, fn;
  logic [4:0]  rs, rt, rd, sh;
  logic [31:0] simm, zimm, pc4, btgt, ea;
  assign opc  = iw[31:26];
  assign rs   = iw[25:21];
  assign rt   = iw[20:16];
  assign rd   = iw[15:11];
  assign sh   = iw[10:6];
  assign fn   = iw[5:0];
  assign zimm = {16'd0, iw[15:0]};
  assign simm = {{16{iw[15]}}, iw[15:0]};
  assign pc4  = pc + 32'd4;
  assign btgt = pc4 + {simm[29:0], 2'b00};
  assign ea   = ra + simm;

  // shared alu request, used in the writeback step
  alu_req_t    areq;
  logic [31:0] ay;
  logic        a_wr;
  logic [4:0]  a_dst;
  m32ie_alu u_alu (.req(areq), .y(ay));

  always_comb begin
    areq = '{op: U_ADD, a: ra, b: rb};
    a_wr = 1'b0;
    a_dst = rd;
    if (opc == 6'h00) begin
      a_wr = 1'b1;
      unique case (fn)
        6'h20, 6'h21: areq.op = U_ADD;
        6'h22, 6'h23: areq.op = U_SUB;
        6'h24: areq.op = U_AND;
        6'h25: areq.op = U_OR;
        6'h26: areq.op = U_XOR;
        6'h27: areq.op = U_NOR;
        6'h2a: areq.op = U_SLT;
        6'h2b: areq.op = U_SLTU;
        6'h00: areq = '{op: U_SLL, a: {27'd0, sh}, b: rb};
        6'h02: areq = '{op: U_SRL, a: {27'd0, sh}, b: rb};
        6'h03: areq = '{op: U_SRA, a: {27'd0, sh}, b: rb};
        6'h04: areq.op = U_SLL;
        6'h06: areq.op = U_SRL;
        6'h07: areq.op = U_SRA;
        default: a_wr = 1'b0;
      endcase
    end else begin
      a_dst = rt;
      a_wr = 1'b1;
      unique case (opc)
        6'h08, 6'h09: areq = '{op: U_ADD, a: ra, b: simm};
        6'h0a: areq = '{op: U_SLT, a: ra, b: simm};
        6'h0b: areq = '{op: U_SLTU, a: ra, b: simm};
        6'h0c: areq = '{op: U_AND, a: ra, b: zimm};
        6'h0d: areq = '{op: U_OR, a: ra, b: zimm};
        6'h0e: areq = '{op: U_XOR, a: ra, b: zimm};
        6'h0f: areq = '{op: U_LUI, a: ra, b: zimm};
        default: a_wr = 1'b0;
      endcase
    end
  end

  // load lane extraction
  logic [7:0]  lb;
  logic [15:0] lh;
  logic [31:0] lval;
  always_comb begin
    lb = ldw[8*pend_off +: 8];
    lh = ldw[16*pend_off[1] +: 16];
    unique case (pend_kind)
      3'd0: lval = {{24{lb[7]}}, lb};
      3'd1: lval = {24'd0, lb};
      3'd2: lval = {{16{lh[15]}}, lh};
      3'd3: lval = {16'd0, lh};
      default: lval = ldw;
    endcase
  end

  // divide step: shift remainder, trial subtract
  logic [32:0] dtrial;
  assign dtrial = {acc, mq[31]} - {1'b0, dv};
  // multiply step: add multiplicand when lsb set
  logic [32:0] msum;
  assign msum = {1'b0, acc} + (mq[0] ? {1'b0, dv} : 33'd0);

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    rf_we <= 1'b0;
    if (rst) begin
      state <= S_CLR;
      clr_idx <= '0;
      pc <= StartReset;
      hi <= '0;
      lo <= '0;
      halt_flag <= 1'b0;
      pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          // sweep zeros through the register file
          rf_we <= 1'b1;
          rf_waddr <= clr_idx;
          rf_wdata <= '0;
          clr_idx <= clr_idx + 5'd1;
          if (clr_idx == 5'd31) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            iw <= in_data.instruction_word;
            ldw <= in_data.load_data;
            out_data <= '{fetch_address: pc, memory_request: REQ_NONE,
                          memory_address: '0, store_data: '0, byte_enables: '0,
                          halted: halt_flag, status: ST_OK};
            if (in_data.operation == OP_LOAD) begin
              state <= pend ? S_LD : S_OUT;
            end else if (pend) begin
              out_data.memory_request <= REQ_READ;
              out_data.memory_address <= pend_addr;
              state <= S_OUT;
            end else if (halt_flag) begin
              state <= S_OUT;
            end else begin
              rf_raddr <= in_data.instruction_word[25:21];
              state <= S_RDA;
            end
          end
        end
        S_LD: begin
          pend <= 1'b0;
          if (pend_tgt != 5'd0) begin
            rf_we <= 1'b1;
            rf_waddr <= pend_tgt;
            rf_wdata <= lval;
          end
          state <= S_OUT;
        end
        S_RDA: begin
          rf_raddr <= rt;
          state <= S_RDB;
        end
        S_RDB: begin
          ra <= (rs == 5'd0) ? 32'd0 : rf_rdata;
          rf_raddr <= 5'd2;
          state <= S_EXE;
        end
        S_EXE: begin : exe
          logic [31:0] b;
          b = (rt == 5'd0) ? 32'd0 : rf_rdata;
          rb <= b;
          pc <= pc4;
          out_data.fetch_address <= pc4;
          state <= S_OUT;
          // alu-class ops use the shared unit on rb later, so ops here use b
          if (opc == 6'h00) begin
            unique case (fn)
              6'h08, 6'h09: begin
                if (fn == 6'h09 && rd != 5'd0) begin
                  rf_we <= 1'b1; rf_waddr <= rd; rf_wdata <= pc4;
                end
                if (ra[1:0] == 2'b00) begin
                  pc <= ra; out_data.fetch_address <= ra;
                end else begin
                  out_data.status <= ST_MISALIGN;
                end
              end
              6'h10: if (rd != 5'd0) begin
                rf_we <= 1'b1; rf_waddr <= rd; rf_wdata <= hi;
              end
              6'h12: if (rd != 5'd0) begin
                rf_we <= 1'b1; rf_waddr <= rd; rf_wdata <= lo;
              end
              6'h11: hi <= ra;
              6'h13: lo <= ra;
              6'h18, 6'h19: begin
                is_signed <= !fn[0];
                acc <= '0;
                mq <= b;
                dv <= ra;
                cnt <= '0;
                state <= S_MUL;
              end
              6'h1a, 6'h1b: begin
                if (b == 32'd0) begin
                  out_data.status <= ST_DIVZERO;
                end else begin
                  is_signed <= !fn[0];
                  neg_q <= !fn[0] && (ra[31] != b[31]);
                  neg_r <= !fn[0] && ra[31];
                  acc <= '0;
                  mq <= (!fn[0] && ra[31]) ? -ra : ra;
                  dv <= (!fn[0] && b[31]) ? -b : b;
                  cnt <= '0;
                  state <= S_DIV;
                end
              end
              // r2 arrives on the read port next cycle
              6'h0c: state <= S_FIX;
              default: begin
                if (!a_wr) begin
                  out_data.status <= ST_UNIMP;
                end else begin
                  state <= S_FIX;
                end
              end
            endcase
          end else begin
            unique case (opc)
              6'h01: begin
                if (rt == 5'h00 || rt == 5'h10 || rt == 5'h01 || rt == 5'h11) begin
                  if (rt[4]) begin
                    rf_we <= 1'b1; rf_waddr <= 5'd31; rf_wdata <= pc4;
                  end
                  if (ra[31] != rt[0]) begin
                    pc <= btgt; out_data.fetch_address <= btgt;
                  end
                end else begin
                  out_data.status <= ST_UNIMP;
                end
              end
              6'h02, 6'h03: begin
                if (opc[0]) begin
                  rf_we <= 1'b1; rf_waddr <= 5'd31; rf_wdata <= pc4;
                end
                pc <= {pc4[31:28], iw[25:0], 2'b00};
                out_data.fetch_address <= {pc4[31:28], iw[25:0], 2'b00};
              end
              6'h04: if (ra == b) begin
                pc <= btgt; out_data.fetch_address <= btgt;
              end
              6'h05: if (ra != b) begin
                pc <= btgt; out_data.fetch_address <= btgt;
              end
              6'h06: if (ra == 32'd0 || ra[31]) begin
                pc <= btgt; out_data.fetch_address <= btgt;
              end
              6'h07: if (ra != 32'd0 && !ra[31]) begin
                pc <= btgt; out_data.fetch_address <= btgt;
              end
              6'h20, 6'h24, 6'h21, 6'h25, 6'h23: begin
                pend <= 1'b1;
                pend_kind <= (opc == 6'h20) ? 3'd0 : (opc == 6'h24) ? 3'd1 :
                             (opc == 6'h21) ? 3'd2 : (opc == 6'h25) ? 3'd3 : 3'd4;
                pend_tgt <= rt;
                pend_off <= ea[1:0];
                pend_addr <= ea;
                out_data.memory_request <= REQ_READ;
                out_data.memory_address <= ea;
              end
              6'h28: begin
                out_data.memory_request <= REQ_WRITE;
                out_data.memory_address <= ea;
                out_data.store_data <= {24'd0, b[7:0]} << {ea[1:0], 3'b000};
                out_data.byte_enables <= 4'b0001 << ea[1:0];
              end
              6'h29: begin
                out_data.memory_request <= REQ_WRITE;
                out_data.memory_address <= ea;
                out_data.store_data <= ea[1] ? {b[15:0], 16'd0} : {16'd0, b[15:0]};
                out_data.byte_enables <= ea[1] ? 4'b1100 : 4'b0011;
              end
              6'h2b: begin
                out_data.memory_request <= REQ_WRITE;
                out_data.memory_address <= ea;
                out_data.store_data <= b;
                out_data.byte_enables <= 4'hF;
              end
              default: begin
                if (a_wr) begin
                  state <= S_FIX;
                end else begin
                  out_data.status <= ST_UNIMP;
                end
              end
            endcase
          end
        end
        S_FIX: begin
          // writeback through the shared alu, or syscall check on r2
          if (opc == 6'h00 && fn == 6'h0c) begin
            if (rf_rdata == 32'd10) begin
              halt_flag <= 1'b1;
              out_data.halted <= 1'b1;
            end
          end else if (a_dst != 5'd0) begin
            rf_we <= 1'b1;
            rf_waddr <= a_dst;
            rf_wdata <= ay;
          end
          state <= S_OUT;
        end
        S_MUL: begin
          // shift-add: {acc,mq} >>= 1 after conditional add
          acc <= msum[32:1];
          mq <= {msum[0], mq[31:1]};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd31) begin
            state <= S_OUT;
            lo <= {msum[0], mq[31:1]};
            hi <= is_signed ? msum[32:1] - (dv[31] ? rb : 32'd0) - (rb[31] ? dv : 32'd0)
                            : msum[32:1];
          end
        end
        S_DIV: begin
          if (!dtrial[32]) begin
            acc <= dtrial[31:0];
          end else begin
            acc <= {acc[30:0], mq[31]};
          end
          mq <= {mq[30:0], !dtrial[32]};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd31) begin
            state <= S_OUT;
            lo <= neg_q ? -{mq[30:0], !dtrial[32]} : {mq[30:0], !dtrial[32]};
            hi <= neg_r ? -(dtrial[32] ? {acc[30:0], mq[31]} : dtrial[31:0])
                        : (dtrial[32] ? {acc[30:0], mq[31]} : dtrial[31:0]);
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // configuration register, back to its default on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      start_address <= StartReset;
    end else if (cfg_we) begin
      start_address <= cfg_wdata;
    end
  end

  // start_address is held only, nothing reads it back
  logic unused_ok;
  assign unused_ok = ^start_address;
endmodule
`default_nettype wire

/* src/m32ie_checker.sv */
// port-level checker for the mips32 execute block
`timescale 1ns / 1ps
`default_nettype none
`include "mips32_instruction_execute_defines.svh"
module m32ie_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire m32ie_pkg::out_item_t out_data
);
  import m32ie_pkg::*;
  `CHK_IMPL(a_busy, out_valid, !in_ready, "input taken while result pending")
  `CHK_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped")
  `CHK_NEXT(a_one, in_valid && in_ready, !in_ready, "second input accepted in flight")
  `CHK_IMPL(a_req, out_valid, out_data.memory_request != 2'd3, "bad request code")
endmodule
bind mips32_instruction_execute m32ie_checker u_chk (.*);
`default_nettype wire

/* verif/mips32_instruction_execute_tb.sv */
// self-checking testbench for the mips32 execute block
`timescale 1ns / 1ps
module mips32_instruction_execute_tb;
  import m32ie_pkg::*;

  // primary opcodes
  localparam logic [5:0] OPC_SPECIAL = 6'h00;
  localparam logic [5:0] OPC_REGIMM = 6'h01;
  localparam logic [5:0] OPC_J = 6'h02;
  localparam logic [5:0] OPC_JAL = 6'h03;
  localparam logic [5:0] OPC_BEQ = 6'h04;
  localparam logic [5:0] OPC_BNE = 6'h05;
  localparam logic [5:0] OPC_BLEZ = 6'h06;
  localparam logic [5:0] OPC_BGTZ = 6'h07;
  localparam logic [5:0] OPC_ADDI = 6'h08;
  localparam logic [5:0] OPC_ADDIU = 6'h09;
  localparam logic [5:0] OPC_SLTI = 6'h0a;
  localparam logic [5:0] OPC_SLTIU = 6'h0b;
  localparam logic [5:0] OPC_ANDI = 6'h0c;
  localparam logic [5:0] OPC_ORI = 6'h0d;
  localparam logic [5:0] OPC_XORI = 6'h0e;
  localparam logic [5:0] OPC_LUI = 6'h0f;
  localparam logic [5:0] OPC_LB = 6'h20;
  localparam logic [5:0] OPC_LH = 6'h21;
  localparam logic [5:0] OPC_LW = 6'h23;
  localparam logic [5:0] OPC_LBU = 6'h24;
  localparam logic [5:0] OPC_LHU = 6'h25;
  localparam logic [5:0] OPC_SB = 6'h28;
  localparam logic [5:0] OPC_SH = 6'h29;
  localparam logic [5:0] OPC_SW = 6'h2b;
  localparam logic [5:0] OPC_BOGUS = 6'h3f;
  // special function codes
  localparam logic [5:0] FN_SLL = 6'h00;
  localparam logic [5:0] FN_SRL = 6'h02;
  localparam logic [5:0] FN_SRA = 6'h03;
  localparam logic [5:0] FN_SLLV = 6'h04;
  localparam logic [5:0] FN_SRLV = 6'h06;
  localparam logic [5:0] FN_SRAV = 6'h07;
  localparam logic [5:0] FN_JR = 6'h08;
  localparam logic [5:0] FN_JALR = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0c;
  localparam logic [5:0] FN_MFHI = 6'h10;
  localparam logic [5:0] FN_MTHI = 6'h11;
  localparam logic [5:0] FN_MFLO = 6'h12;
  localparam logic [5:0] FN_MTLO = 6'h13;
  localparam logic [5:0] FN_MULT = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19;
  localparam logic [5:0] FN_DIV = 6'h1a;
  localparam logic [5:0] FN_DIVU = 6'h1b;
  localparam logic [5:0] FN_ADD = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB = 6'h22;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND = 6'h24;
  localparam logic [5:0] FN_OR = 6'h25;
  localparam logic [5:0] FN_XOR = 6'h26;
  localparam logic [5:0] FN_NOR = 6'h27;
  localparam logic [5:0] FN_SLT = 6'h2a;
  localparam logic [5:0] FN_SLTU = 6'h2b;
  localparam logic [5:0] FN_BOGUS = 6'h3f;
  // regimm rt codes
  localparam logic [4:0] RI_BLTZ = 5'h00;
  localparam logic [4:0] RI_BGEZ = 5'h01;
  localparam logic [4:0] RI_BOGUS = 5'h02;
  localparam logic [4:0] RI_BLTZAL = 5'h10;
  localparam logic [4:0] RI_BGEZAL = 5'h11;

  localparam logic [31:0] EXIT_CODE = 32'd10;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned RANDOM_PER_PHASE = 620;

  // shadow copy of the core state, predicts one result per transaction
  class mips_core_mirror;
    logic [31:0] regs [32];
    logic [31:0] pc, hi, lo, start_addr, pend_addr;
    logic        halted, pend_valid;
    logic [5:0]  pend_opc;
    logic [4:0]  pend_rd;
    logic [1:0]  pend_off;
    out_item_t   awaited_outputs[$];

    function new();
      foreach (regs[i]) regs[i] = '0;
      start_addr = START_ADDRESS_RESET;
      pc = start_addr;
      hi = '0; lo = '0; pend_addr = '0;
      halted = 1'b0; pend_valid = 1'b0;
      pend_opc = '0; pend_rd = '0; pend_off = '0;
    endfunction

    // start address only matters at reset, which happens once
    function void set_start(logic [31:0] v);
      start_addr = v;
    endfunction

    function void put(logic [4:0] r, logic [31:0] v);
      if (r != 5'd0) regs[r] = v;
    endfunction

    function void note_instruction(in_item_t it);
      out_item_t   r;
      logic [31:0] w, a, b, pc4, simm, imm, btgt, ea, npc, ma, mb, q, rm, v, bsel, hsel;
      logic [63:0] p;
      logic [5:0]  opc, fn;
      logic [4:0]  rs, rt, rd, sh;
      logic [1:0]  off;
      r = '0;
      if (it.operation == OP_LOAD) begin
        if (pend_valid) begin
          bsel = (it.load_data >> (8 * pend_off)) & 32'hff;
          hsel = pend_off[1] ? {16'h0, it.load_data[31:16]} : {16'h0, it.load_data[15:0]};
          case (pend_opc)
            OPC_LB:  v = {{24{bsel[7]}}, bsel[7:0]};
            OPC_LBU: v = bsel;
            OPC_LH:  v = {{16{hsel[15]}}, hsel[15:0]};
            OPC_LHU: v = hsel;
            default: v = it.load_data;
          endcase
          put(pend_rd, v);
          pend_valid = 1'b0;
        end
        r.fetch_address = pc;
        r.halted = halted;
        awaited_outputs.push_back(r);
        return;
      end
      // execute while a load waits: the read request is repeated
      if (pend_valid) begin
        r.fetch_address = pc;
        r.memory_request = REQ_READ;
        r.memory_address = pend_addr;
        r.halted = halted;
        awaited_outputs.push_back(r);
        return;
      end
      if (halted) begin
        r.fetch_address = pc;
        r.halted = 1'b1;
        awaited_outputs.push_back(r);
        return;
      end
      w = it.instruction_word;
      opc = w[31:26]; rs = w[25:21]; rt = w[20:16]; rd = w[15:11]; sh = w[10:6];
      fn = w[5:0];
      imm = {16'h0, w[15:0]};
      simm = {{16{w[15]}}, w[15:0]};
      a = regs[rs]; b = regs[rt];
      pc4 = pc + 32'd4;
      btgt = pc4 + (simm << 2);
      ea = a + simm;
      off = ea[1:0];
      npc = pc4;
      r.status = ST_OK;
      case (opc)
        OPC_SPECIAL: begin
          case (fn)
            FN_ADD, FN_ADDU: put(rd, a + b);
            FN_SUB, FN_SUBU: put(rd, a - b);
            FN_AND:  put(rd, a & b);
            FN_OR:   put(rd, a | b);
            FN_XOR:  put(rd, a ^ b);
            FN_NOR:  put(rd, ~(a | b));
            FN_SLT:  put(rd, {31'd0, $signed(a) < $signed(b)});
            FN_SLTU: put(rd, {31'd0, a < b});
            FN_SLL:  put(rd, b << sh);
            FN_SRL:  put(rd, b >> sh);
            FN_SRA:  put(rd, $signed(b) >>> sh);
            FN_SLLV: put(rd, b << a[4:0]);
            FN_SRLV: put(rd, b >> a[4:0]);
            FN_SRAV: put(rd, $signed(b) >>> a[4:0]);
            FN_JR, FN_JALR: begin
              if (fn == FN_JALR) put(rd, pc4);
              if (a[1:0] == 2'b00) npc = a;
              else r.status = ST_MISALIGN;
            end
            FN_MFHI: put(rd, hi);
            FN_MFLO: put(rd, lo);
            FN_MTHI: hi = a;
            FN_MTLO: lo = a;
            FN_MULT: begin
              p = {{32{a[31]}}, a} * {{32{b[31]}}, b};
              hi = p[63:32]; lo = p[31:0];
            end
            FN_MULTU: begin
              p = {32'd0, a} * {32'd0, b};
              hi = p[63:32]; lo = p[31:0];
            end
            FN_DIV, FN_DIVU: begin
              if (b == 32'd0) r.status = ST_DIVZERO;
              else if (fn == FN_DIVU) begin
                lo = a / b; hi = a % b;
              end else begin
                ma = a[31] ? -a : a;
                mb = b[31] ? -b : b;
                q = ma / mb; rm = ma % mb;
                lo = (a[31] != b[31]) ? -q : q;
                hi = a[31] ? -rm : rm;
              end
            end
            FN_SYSCALL: if (regs[2] == EXIT_CODE) halted = 1'b1;
            default: r.status = ST_UNIMP;
          endcase
        end
        OPC_REGIMM: begin
          case (rt)
            RI_BLTZ, RI_BLTZAL: begin
              if (rt == RI_BLTZAL) put(5'd31, pc4);
              if (a[31]) npc = btgt;
            end
            RI_BGEZ, RI_BGEZAL: begin
              if (rt == RI_BGEZAL) put(5'd31, pc4);
              if (!a[31]) npc = btgt;
            end
            default: r.status = ST_UNIMP;
          endcase
        end
        OPC_J, OPC_JAL: begin
          if (opc == OPC_JAL) put(5'd31, pc4);
          npc = {pc4[31:28], w[25:0], 2'b00};
        end
        OPC_BEQ:  if (a == b) npc = btgt;
        OPC_BNE:  if (a != b) npc = btgt;
        OPC_BLEZ: if ($signed(a) <= 0) npc = btgt;
        OPC_BGTZ: if ($signed(a) > 0) npc = btgt;
        OPC_ADDI, OPC_ADDIU: put(rt, a + simm);
        OPC_SLTI:  put(rt, {31'd0, $signed(a) < $signed(simm)});
        OPC_SLTIU: put(rt, {31'd0, a < simm});
        OPC_ANDI:  put(rt, a & imm);
        OPC_ORI:   put(rt, a | imm);
        OPC_XORI:  put(rt, a ^ imm);
        OPC_LUI:   put(rt, imm << 16);
        OPC_LB, OPC_LBU, OPC_LH, OPC_LHU, OPC_LW: begin
          pend_valid = 1'b1; pend_opc = opc; pend_rd = rt; pend_off = off;
          pend_addr = ea;
          r.memory_request = REQ_READ;
          r.memory_address = ea;
        end
        OPC_SB: begin
          r.memory_request = REQ_WRITE; r.memory_address = ea;
          r.store_data = {24'd0, b[7:0]} << (8 * off);
          r.byte_enables = 4'b0001 << off;
        end
        OPC_SH: begin
          r.memory_request = REQ_WRITE; r.memory_address = ea;
          r.store_data = {16'd0, b[15:0]} << (16 * off[1]);
          r.byte_enables = 4'b0011 << (2 * off[1]);
        end
        OPC_SW: begin
          r.memory_request = REQ_WRITE; r.memory_address = ea;
          r.store_data = b; r.byte_enables = 4'hf;
        end
        default: r.status = ST_UNIMP;
      endcase
      pc = npc;
      r.fetch_address = pc;
      r.halted = halted;
      awaited_outputs.push_back(r);
    endfunction

    // returns an empty string when the result matches the oldest prediction
    function string check_result(out_item_t got);
      out_item_t e;
      string     s;
      if (awaited_outputs.size() == 0)
        return $sformatf("result with nothing predicted: %h", got);
      e = awaited_outputs.pop_front();
      s = "";
      if (got.fetch_address !== e.fetch_address)
        s = {s, $sformatf(" fetch_address %h/%h", got.fetch_address, e.fetch_address)};
      if (got.memory_request !== e.memory_request)
        s = {s, $sformatf(" memory_request %0d/%0d", got.memory_request, e.memory_request)};
      if (got.memory_address !== e.memory_address)
        s = {s, $sformatf(" memory_address %h/%h", got.memory_address, e.memory_address)};
      if (got.store_data !== e.store_data)
        s = {s, $sformatf(" store_data %h/%h", got.store_data, e.store_data)};
      if (got.byte_enables !== e.byte_enables)
        s = {s, $sformatf(" byte_enables %h/%h", got.byte_enables, e.byte_enables)};
      if (got.halted !== e.halted)
        s = {s, $sformatf(" halted %b/%b", got.halted, e.halted)};
      if (got.status !== e.status)
        s = {s, $sformatf(" status %0d/%0d", got.status, e.status)};
      if (s != "") s = {"got/predicted:", s};
      return s;
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  mips32_instruction_execute DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  mips_core_mirror mirror = new();
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned quiet_cycles = 0;
  // set while a load was issued and its data transaction is still owed
  logic load_owed = 1'b0;

  task automatic report(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // both transaction monitors; values sampled here are the pre-edge ones
  always @(posedge clk) begin
    string msg;
    if (!rst && in_valid && in_ready) mirror.note_instruction(in_data);
    if (!rst && out_valid && out_ready) begin
      msg = mirror.check_result(out_data);
      if (msg != "") report(msg);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [31:0] r_word(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                         logic [4:0] rd, logic [4:0] sh);
    return {OPC_SPECIAL, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] i_word(logic [5:0] opc, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
    return {opc, rs, rt, imm};
  endfunction

  // drive one transaction and hold it until accepted
  task automatic send(logic op, logic [31:0] word, logic [31:0] data);
    in_item_t it;
    it.operation = op;
    it.instruction_word = word;
    it.load_data = data;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic exec(logic [31:0] word);
    send(OP_EXEC, word, $urandom);
  endtask

  task automatic give_data(logic [31:0] data);
    send(OP_LOAD, $urandom, data);
  endtask

  // quiet point: everything drained, then the block's own tail
  task automatic drain();
    in_valid <= 1'b0;
    while (mirror.awaited_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_start(logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    mirror.set_start(v);
  endtask

  function automatic logic is_load_opc(logic [5:0] opc);
    return opc == OPC_LB || opc == OPC_LBU || opc == OPC_LH || opc == OPC_LHU ||
           opc == OPC_LW;
  endfunction

  // one random transaction, mostly well-formed programs with random content
  task automatic random_item();
    logic [5:0]  alu_fns [14] = '{FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR,
                                  FN_NOR, FN_SLT, FN_SLTU, FN_SLL, FN_SRL, FN_SRA, FN_SLLV};
    logic [5:0]  imm_ops [8] = '{OPC_ADDI, OPC_ADDIU, OPC_SLTI, OPC_SLTIU, OPC_ANDI, OPC_ORI,
                                 OPC_XORI, OPC_LUI};
    logic [5:0]  ld_ops [5] = '{OPC_LB, OPC_LBU, OPC_LH, OPC_LHU, OPC_LW};
    logic [5:0]  st_ops [3] = '{OPC_SB, OPC_SH, OPC_SW};
    logic [5:0]  br_ops [5] = '{OPC_BEQ, OPC_BNE, OPC_BLEZ, OPC_BGTZ, OPC_REGIMM};
    logic [4:0]  ri_codes [4] = '{RI_BLTZ, RI_BGEZ, RI_BLTZAL, RI_BGEZAL};
    logic [5:0]  md_fns [10] = '{FN_MULT, FN_MULTU, FN_DIV, FN_DIVU, FN_MTHI, FN_MTLO,
                                 FN_MFHI, FN_MFLO, FN_SRLV, FN_SRAV};
    logic [31:0] w;
    logic [5:0]  opc;
    int unsigned pick;
    pick = $urandom_range(99);
    w = $urandom;
    if (load_owed) begin
      if (pick < 88) begin
        give_data($urandom);
        load_owed = 1'b0;
      end else begin
        exec(w);  // ignored, the read request is repeated
      end
      return;
    end
    if (pick >= 93 && pick < 97) begin
      give_data($urandom);  // stray data, nothing pending
      return;
    end
    if (pick < 28) w = r_word(alu_fns[$urandom_range(13)], w[25:21], w[20:16], w[15:11],
                              w[10:6]);
    else if (pick < 44) w = i_word(imm_ops[$urandom_range(7)], w[25:21], w[20:16], w[15:0]);
    else if (pick < 54) w = i_word(ld_ops[$urandom_range(4)], w[25:21], w[20:16], w[15:0]);
    else if (pick < 62) w = i_word(st_ops[$urandom_range(2)], w[25:21], w[20:16], w[15:0]);
    else if (pick < 70) begin
      opc = br_ops[$urandom_range(4)];
      w = i_word(opc, w[25:21], opc == OPC_REGIMM ? ri_codes[$urandom_range(3)] : w[20:16],
                 w[15:0]);
    end else if (pick < 73) w = {($urandom_range(1) ? OPC_JAL : OPC_J), w[25:0]};
    else if (pick < 79) w = r_word($urandom_range(1) ? FN_JALR : FN_JR, w[25:21], w[20:16],
                                   w[15:11], w[10:6]);
    else if (pick < 87) w = r_word(md_fns[$urandom_range(9)], w[25:21], w[20:16], w[15:11],
                                   w[10:6]);
    else if (pick >= 97) begin
      if ($urandom_range(1)) w = i_word(OPC_REGIMM, w[25:21], RI_BOGUS, w[15:0]);
      else w = r_word(FN_BOGUS, w[25:21], w[20:16], w[15:11], w[10:6]);
    end
    // raw words keep their bits, except an exit call stays for the end
    if (w[31:26] == OPC_SPECIAL && w[5:0] == FN_SYSCALL) w[5:0] = FN_BOGUS;
    if (is_load_opc(w[31:26])) load_owed = 1'b1;
    exec(w);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    write_start(32'hffff_ffff);

    // directed: signed extremes, wrap, divide corners, lanes, odd cases
    send_idle_pct = 12; recv_idle_pct = 71;
    exec(i_word(OPC_LUI, 5'd0, 5'd1, 16'h8000));            // r1 = 0x80000000
    exec(i_word(OPC_ADDI, 5'd0, 5'd2, 16'hffff));           // r2 = -1
    exec(r_word(FN_ADD, 5'd1, 5'd2, 5'd3, 5'd0));           // overflow wraps
    exec(r_word(FN_SUB, 5'd1, 5'd2, 5'd4, 5'd0));
    exec(r_word(FN_DIV, 5'd1, 5'd2, 5'd0, 5'd0));           // most negative by -1
    exec(r_word(FN_MFLO, 5'd0, 5'd0, 5'd5, 5'd0));
    exec(r_word(FN_MFHI, 5'd0, 5'd0, 5'd6, 5'd0));
    exec(r_word(FN_DIVU, 5'd2, 5'd0, 5'd0, 5'd0));          // zero divisor
    exec(r_word(FN_MULT, 5'd1, 5'd2, 5'd0, 5'd0));
    exec(r_word(FN_SRA, 5'd0, 5'd1, 5'd7, 5'd31));
    exec(r_word(FN_JR, 5'd2, 5'd0, 5'd0, 5'd0));            // misaligned target
    exec(r_word(FN_JALR, 5'd2, 5'd0, 5'd9, 5'd0));          // misaligned, rd written
    exec({OPC_BOGUS, 26'h3ff_ffff});
    exec(i_word(OPC_REGIMM, 5'd1, RI_BOGUS, 16'h0010));
    exec(i_word(OPC_BLEZ, 5'd1, 5'd0, 16'hfffe));           // signed compare
    exec(i_word(OPC_BGTZ, 5'd1, 5'd0, 16'h7fff));
    exec(i_word(OPC_LB, 5'd2, 5'd0, 16'h0004));             // load to r0, offset 3
    exec(i_word(OPC_ADDI, 5'd0, 5'd8, 16'h0001));           // ignored while pending
    give_data(32'h80ff_7f01);
    exec(i_word(OPC_LH, 5'd2, 5'd10, 16'h0004));
    give_data(32'h8000_7fff);
    give_data(32'hffff_ffff);                               // nothing pending
    exec(i_word(OPC_SB, 5'd2, 5'd2, 16'h0002));
    exec(i_word(OPC_SH, 5'd2, 5'd1, 16'h0004));
    exec(i_word(OPC_SW, 5'd1, 5'd2, 16'h7fff));
    exec(r_word(FN_SYSCALL, 5'd0, 5'd0, 5'd0, 5'd0));       // r2 is not the exit code
    exec({OPC_J, 26'h3ff_ffff});

    repeat (RANDOM_PER_PHASE) random_item();
    drain();
    write_start(32'h0000_0000);

    send_idle_pct = 71; recv_idle_pct = 12;
    repeat (RANDOM_PER_PHASE) random_item();
    drain();
    write_start($urandom);

    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (RANDOM_PER_PHASE) random_item();
    if (load_owed) give_data($urandom);
    // exit call, then transactions that must change nothing
    exec(i_word(OPC_ADDIU, 5'd0, 5'd2, 16'd10));
    exec(r_word(FN_SYSCALL, 5'd0, 5'd0, 5'd0, 5'd0));
    exec(i_word(OPC_ADDIU, 5'd0, 5'd3, 16'h1234));
    exec(i_word(OPC_LW, 5'd0, 5'd3, 16'h0000));
    give_data($urandom);
    drain();

    if (mirror.awaited_outputs.size() != 0)
      report($sformatf("%0d predicted results never came", mirror.awaited_outputs.size()));
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
